>>> rtl/midi_pkg.sv
package midi_pkg;

    localparam int unsigned ByteW   = 8;
    localparam int unsigned TypeW   = 5;
    localparam int unsigned ChanW   = 5;
    localparam int unsigned LenW    = 2;
    localparam int unsigned KindW   = 2;
    localparam int unsigned OutDataW = 40;

    localparam logic [ByteW-1:0] StatusBit = 8'h80;
    localparam logic [ByteW-1:0] SysBase   = 8'hF0;

    typedef enum logic [KindW-1:0] {
        KIND_COMPLETE  = 2'd0,
        KIND_TRUNCATED = 2'd1,
        KIND_STRAY     = 2'd2
    } t_kind;

    // Type codes
    localparam logic [TypeW-1:0] TypeSysex    = 5'd7;
    localparam logic [TypeW-1:0] TypeTimeCode = 5'd8;
    localparam logic [TypeW-1:0] TypeSongPos  = 5'd9;
    localparam logic [TypeW-1:0] TypeSongSel  = 5'd10;
    localparam logic [TypeW-1:0] TypeTune     = 5'd11;
    localparam logic [TypeW-1:0] TypeEox      = 5'd12;
    localparam logic [TypeW-1:0] TypeClock    = 5'd13;
    localparam logic [TypeW-1:0] TypeStart    = 5'd14;
    localparam logic [TypeW-1:0] TypeContinue = 5'd15;
    localparam logic [TypeW-1:0] TypeStop     = 5'd16;
    localparam logic [TypeW-1:0] TypeSensing  = 5'd17;
    localparam logic [TypeW-1:0] TypeReset    = 5'd18;
    localparam logic [TypeW-1:0] TypeUnknown  = 5'd19;

    typedef struct packed {
        logic [LenW-1:0]  byte_count;
        logic [ByteW-1:0] second_data;
        logic [ByteW-1:0] first_data;
        logic [ChanW-1:0] channel_number;
        logic [TypeW-1:0] type_code;
        logic [ByteW-1:0] status_byte;
    } t_fields;

    typedef struct packed {
        t_kind   kind;
        t_fields fields;
    } t_result;

    function automatic logic [LenW-1:0] msg_length(input logic [ByteW-1:0] s);
        logic [LenW-1:0] len;
        len = 2'd1;
        case (s[7:4])
            4'hC, 4'hD:                   len = 2'd2;
            4'h8, 4'h9, 4'hA, 4'hB, 4'hE: len = 2'd3;
            4'hF: begin
                if (s inside {8'hF1, 8'hF3}) begin
                    len = 2'd2;
                end else if (s == 8'hF2) begin
                    len = 2'd3;
                end
            end
            default: len = 2'd1;
        endcase
        return len;
    endfunction

    function automatic logic [TypeW-1:0] msg_type(input logic [ByteW-1:0] s);
        logic [TypeW-1:0] t;
        t = TypeUnknown;
        if (s < SysBase) begin
            t = {2'b00, s[6:4]};
        end else begin
            case (s[3:0])
                4'h0:    t = TypeSysex;
                4'h1:    t = TypeTimeCode;
                4'h2:    t = TypeSongPos;
                4'h3:    t = TypeSongSel;
                4'h6:    t = TypeTune;
                4'h7:    t = TypeEox;
                4'h8:    t = TypeClock;
                4'hA:    t = TypeStart;
                4'hB:    t = TypeContinue;
                4'hC:    t = TypeStop;
                4'hE:    t = TypeSensing;
                4'hF:    t = TypeReset;
                default: t = TypeUnknown;
            endcase
        end
        return t;
    endfunction

    function automatic logic [ChanW-1:0] msg_channel(input logic [ByteW-1:0] s);
        return (s < SysBase) ? ({1'b0, s[3:0]} + 5'd1) : 5'd0;
    endfunction

endpackage

>>> rtl/midi_message_parser_core.sv
// MIDI message parser core.
// Input channel (s_*): one received MIDI byte per transaction on s_tdata,
// with s_tlast high on the final byte of a receive buffer. Status bytes open
// messages of 1 to 3 bytes; following bytes are taken as data.
// Output channel (m_*): one record per completed message, per stray data
// byte, or per message cut short by a buffer end. m_tuser carries the record
// kind, m_tdata the decoded status, type, channel, data bytes and count.
// A record enters the output register, or the skid entry if that one waits, as
// its last byte is accepted. One byte per cycle while s_tready is high; the
// decode sits wholly between the input handshake and the output register.
// Stalling: an output register plus one skid entry decouple the sides, so
// s_tready is a plain register output. While the receiver holds m_tready low
// one further record can be absorbed; after that s_tready drops until the
// skid entry drains.
// Reset (i_rst_n low, synchronous): close any open message, drop both
// output entries; s_tready is high in the first cycle after reset.
module midi_message_parser_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] byte_value
    input  logic        s_tlast,   // buffer_end
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [7:0] status_byte, [12:8] type_code,
                                   // [17:13] channel_number, [25:18] first_data,
                                   // [33:26] second_data, [35:34] byte_count,
                                   // [39:36] zero
    output logic [1:0]  m_tuser    // [1:0] record_kind
);
    import midi_pkg::*;

    // Parser state
    logic             r_open,   n_open;
    logic [ByteW-1:0] r_status, n_status;
    logic [LenW-1:0]  r_exp,    n_exp;
    logic [LenW-1:0]  r_held,   n_held;
    logic [ByteW-1:0] r_first,  n_first;

    // Output register and skid entry
    logic    r_out_valid, n_out_valid;
    t_result r_out,       n_out;
    logic    r_skid_valid, n_skid_valid;
    t_result r_skid,      n_skid;

    logic       s_accept;
    logic       m_accept;
    logic       res_valid;
    t_result    res;
    logic [7:0] b;

    assign s_tready = !r_skid_valid;
    assign s_accept = s_tvalid && s_tready;
    assign m_accept = r_out_valid && m_tready;
    assign b        = s_tdata;

    // Decode one byte against the held state
    always_comb begin
        n_open    = r_open;
        n_status  = r_status;
        n_exp     = r_exp;
        n_held    = r_held;
        n_first   = r_first;
        res_valid = 1'b0;
        res       = '0;
        if (s_accept) begin
            if (!r_open) begin
                if ((b & StatusBit) != 8'h00) begin
                    if (msg_length(b) == 2'd1) begin
                        // Single-byte message: emit at once
                        res_valid                 = 1'b1;
                        res.kind                  = KIND_COMPLETE;
                        res.fields.status_byte    = b;
                        res.fields.type_code      = msg_type(b);
                        res.fields.channel_number = msg_channel(b);
                        res.fields.byte_count     = 2'd1;
                    end else begin
                        n_open   = 1'b1;
                        n_status = b;
                        n_exp    = msg_length(b);
                        n_held   = 2'd1;
                        n_first  = '0;
                    end
                end else begin
                    // Data byte with no message open
                    res_valid              = 1'b1;
                    res.kind               = KIND_STRAY;
                    res.fields.status_byte = b;
                    res.fields.byte_count  = 2'd1;
                end
            end else if (r_held <= 2'd1) begin
                n_first = b;
                n_held  = 2'd2;
                if (r_exp <= 2'd2) begin
                    res_valid                 = 1'b1;
                    res.kind                  = KIND_COMPLETE;
                    res.fields.status_byte    = r_status;
                    res.fields.type_code      = msg_type(r_status);
                    res.fields.channel_number = msg_channel(r_status);
                    res.fields.first_data     = b;
                    res.fields.byte_count     = 2'd2;
                    n_open   = 1'b0;
                    n_status = '0;
                    n_exp    = '0;
                    n_held   = '0;
                    n_first  = '0;
                end
            end else begin
                res_valid                 = 1'b1;
                res.kind                  = KIND_COMPLETE;
                res.fields.status_byte    = r_status;
                res.fields.type_code      = msg_type(r_status);
                res.fields.channel_number = msg_channel(r_status);
                res.fields.first_data     = r_first;
                res.fields.second_data    = b;
                res.fields.byte_count     = 2'd3;
                n_open   = 1'b0;
                n_status = '0;
                n_exp    = '0;
                n_held   = '0;
                n_first  = '0;
            end

            if (s_tlast) begin
                // Buffer ends: report a message still open, then clear
                if (n_open) begin
                    res_valid                 = 1'b1;
                    res.kind                  = KIND_TRUNCATED;
                    res.fields.status_byte    = n_status;
                    res.fields.type_code      = msg_type(n_status);
                    res.fields.channel_number = msg_channel(n_status);
                    res.fields.first_data     = (n_held >= 2'd2) ? n_first : 8'h00;
                    res.fields.second_data    = '0;
                    res.fields.byte_count     = n_held;
                end
                n_open   = 1'b0;
                n_status = '0;
                n_exp    = '0;
                n_held   = '0;
                n_first  = '0;
            end
        end
    end

    // Output register / skid steering
    always_comb begin
        n_out_valid  = r_out_valid;
        n_out        = r_out;
        n_skid_valid = r_skid_valid;
        n_skid       = r_skid;
        if (m_accept || !r_out_valid) begin
            if (r_skid_valid) begin
                n_out        = r_skid;
                n_out_valid  = 1'b1;
                n_skid_valid = 1'b0;
            end else begin
                n_out       = res;
                n_out_valid = res_valid;
            end
        end else if (res_valid) begin
            n_skid       = res;
            n_skid_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open       <= 1'b0;
            r_status     <= '0;
            r_exp        <= '0;
            r_held       <= '0;
            r_first      <= '0;
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_open       <= n_open;
            r_status     <= n_status;
            r_exp        <= n_exp;
            r_held       <= n_held;
            r_first      <= n_first;
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign m_tvalid = r_out_valid;
    assign m_tuser  = r_out.kind;
    assign m_tdata  = {{(OutDataW - $bits(t_fields)){1'b0}}, r_out.fields};

    // Skid entry is only ever filled behind a waiting output entry
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry valid without output entry");

    // A buffer end always leaves the parser closed
    a_buffer_end_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_tvalid && s_tready && s_tlast) |=> !r_open)
        else $error("message left open after buffer end");

    // An open message always holds its status byte, a nonzero held count and an expected length of at least two
    a_open_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_open |-> (r_held != 2'd0 && r_status[7] && r_exp >= 2'd2))
        else $error("open message state inconsistent");

    // Stray records carry one byte and no channel
    a_stray_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && m_tuser == KIND_STRAY) |-> (m_tdata[35:34] == 2'd1
            && m_tdata[17:13] == 5'd0))
        else $error("malformed stray record");

endmodule

>>> dv/midi_record_checker.sv
module midi_record_checker
    import midi_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [7:0]  i_in_byte,
    input  logic        i_in_last,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [39:0] i_out_data,
    input  logic [1:0]  i_out_kind,
    output int          o_fail_count,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  status;
        logic [4:0]  type_code;
        logic [4:0]  channel;
        logic [7:0]  first_data;
        logic [7:0]  second_data;
        logic [1:0]  count;
    } t_midi_record;

    t_midi_record records_due[$];
    int           mismatches;

    // parser state
    logic         msg_open;
    logic [7:0]   msg_status;
    logic [1:0]   msg_len;
    logic [1:0]   msg_held;
    logic [7:0]   msg_first;

    function automatic logic [1:0] frame_len(input logic [7:0] s);
        logic [1:0] n;
        case (s[7:4])
            4'hC, 4'hD: n = 2'd2;
            4'hF: begin
                case (s)
                    8'hF1, 8'hF3: n = 2'd2;
                    8'hF2:        n = 2'd3;
                    default:      n = 2'd1;
                endcase
            end
            default: n = 2'd3;
        endcase
        return n;
    endfunction

    function automatic logic [4:0] type_of(input logic [7:0] s);
        logic [4:0] t;
        if (s[7:4] != 4'hF) begin
            t = {2'b00, s[6:4]};
        end else begin
            case (s)
                8'hF0:   t = TypeSysex;
                8'hF1:   t = TypeTimeCode;
                8'hF2:   t = TypeSongPos;
                8'hF3:   t = TypeSongSel;
                8'hF6:   t = TypeTune;
                8'hF7:   t = TypeEox;
                8'hF8:   t = TypeClock;
                8'hFA:   t = TypeStart;
                8'hFB:   t = TypeContinue;
                8'hFC:   t = TypeStop;
                8'hFE:   t = TypeSensing;
                8'hFF:   t = TypeReset;
                default: t = TypeUnknown;
            endcase
        end
        return t;
    endfunction

    function automatic logic [4:0] channel_of(input logic [7:0] s);
        return (s[7:4] == 4'hF) ? 5'd0 : 5'(s[3:0]) + 5'd1;
    endfunction

    function automatic t_midi_record message_record(input t_kind k, input logic [7:0] s,
                                                    input logic [7:0] d0,
                                                    input logic [7:0] d1,
                                                    input logic [1:0] n);
        return t_midi_record'{k, s, type_of(s), channel_of(s), d0, d1, n};
    endfunction

    function automatic string record_text(input t_midi_record r);
        return $sformatf("kind=%0d status=%02h type=%0d chan=%0d d0=%02h d1=%02h count=%0d",
                         r.kind, r.status, r.type_code, r.channel, r.first_data,
                         r.second_data, r.count);
    endfunction

    // Advance the parser by one received byte; queue the record it causes.
    task automatic parse_byte(input logic [7:0] rx, input logic buf_end);
        if (!msg_open) begin
            if (rx[7]) begin
                if (frame_len(rx) == 2'd1) begin
                    records_due.push_back(message_record(KIND_COMPLETE, rx, 8'd0, 8'd0, 2'd1));
                end else begin
                    msg_open   = 1'b1;
                    msg_status = rx;
                    msg_len    = frame_len(rx);
                    msg_held   = 2'd1;
                    msg_first  = 8'd0;
                end
            end else begin
                records_due.push_back(t_midi_record'{KIND_STRAY, rx, 5'd0, 5'd0,
                                                     8'd0, 8'd0, 2'd1});
            end
        end else if (msg_held == 2'd1) begin
            msg_first = rx;
            msg_held  = 2'd2;
            if (msg_len == 2'd2) begin
                records_due.push_back(message_record(KIND_COMPLETE, msg_status, rx,
                                                     8'd0, 2'd2));
                msg_open = 1'b0;
            end
        end else begin
            records_due.push_back(message_record(KIND_COMPLETE, msg_status, msg_first,
                                                 rx, 2'd3));
            msg_open = 1'b0;
        end

        if (buf_end) begin
            if (msg_open) begin
                records_due.push_back(message_record(KIND_TRUNCATED, msg_status,
                                                     (msg_held == 2'd2) ? msg_first : 8'd0,
                                                     8'd0, msg_held));
            end
            msg_open = 1'b0;
            msg_held = 2'd0;
        end
    endtask

    always @(posedge i_clk) begin
        t_midi_record got;
        t_midi_record want;
        if (!i_rst_n) begin
            msg_open   = 1'b0;
            msg_status = 8'd0;
            msg_len    = 2'd0;
            msg_held   = 2'd0;
            msg_first  = 8'd0;
            mismatches = 0;
            records_due.delete();
        end else begin
            // output side first: a record never stems from a byte taken at this edge
            if (i_out_valid === 1'b1 && i_out_ready === 1'b1) begin
                got = t_midi_record'{t_kind'(i_out_kind), i_out_data[7:0], i_out_data[12:8],
                                     i_out_data[17:13], i_out_data[25:18],
                                     i_out_data[33:26], i_out_data[35:34]};
                if (records_due.size() == 0) begin
                    $display("%0t: record with none expected: %s", $time, record_text(got));
                    mismatches++;
                end else begin
                    want = records_due.pop_front();
                    if (got.kind !== want.kind || got.status !== want.status ||
                        got.type_code !== want.type_code || got.channel !== want.channel ||
                        got.first_data !== want.first_data ||
                        got.second_data !== want.second_data || got.count !== want.count) begin
                        $display("%0t: record mismatch", $time);
                        $display("    expected %s", record_text(want));
                        $display("    actual   %s", record_text(got));
                        mismatches++;
                    end
                end
            end
            if (i_in_valid === 1'b1 && i_in_ready === 1'b1) begin
                parse_byte(i_in_byte, i_in_last);
            end
        end
        o_fail_count <= mismatches;
        o_pending    <= records_due.size();
    end

endmodule

>>> dv/tb_midi_message_parser_core.sv
module tb_midi_message_parser_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ClkPeriod  = 10;
    localparam int CycleLimit = 300000;
    localparam int HoldCycles = 80;

    logic        i_clk    = 1'b0;
    logic        i_rst_n  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [7:0]  s_tdata  = 8'd0;
    logic        s_tlast  = 1'b0;
    logic        m_tready = 1'b0;
    logic        s_tready;
    logic        m_tvalid;
    logic [39:0] m_tdata;
    logic [1:0]  m_tuser;

    int fail_count;
    int pending_count;

    // Idling controls: the sender's chance is read only by the stimulus
    // process, the receiver's is handed over by nonblocking assignment.
    int snd_idle_pct  = 0;
    int rcv_stall_pct = 0;
    int hold_token    = 0;
    int hold_taken    = 0;
    int hold_left     = 0;
    int bytes_sent    = 0;
    int cycle_count   = 0;

    midi_message_parser_core DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    midi_record_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (s_tvalid),
        .i_in_ready   (s_tready),
        .i_in_byte    (s_tdata),
        .i_in_last    (s_tlast),
        .i_out_valid  (m_tvalid),
        .i_out_ready  (m_tready),
        .i_out_data   (m_tdata),
        .i_out_kind   (m_tuser),
        .o_fail_count (fail_count),
        .o_pending    (pending_count)
    );

    always #(ClkPeriod / 2) i_clk = ~i_clk;

    // Give up on a hung run.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CycleLimit) begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    // Receiver: stall at random, or hold off for a long stretch whenever the
    // stimulus asks for one, so that the core fills both output entries and
    // drops s_tready while the sender keeps offering bytes.
    always @(posedge i_clk) begin
        if (hold_token != hold_taken) begin
            hold_taken = hold_token;
            hold_left  = HoldCycles;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= rcv_stall_pct);
        end
    end

    // Offer one byte and hold it until the transaction completes. Idle
    // cycles come first, each drawn with the sender's idle chance.
    task automatic send_byte(input logic [7:0] rx, input logic buf_end);
        while (snd_idle_pct > 0 && $urandom_range(99) < snd_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= rx;
        s_tlast  <= buf_end;
        @(posedge i_clk);
        while (!s_tready) begin
            @(posedge i_clk);
        end
        bytes_sent++;
    endtask

    // Mostly data bytes below 0x80, but let the top bit through now and
    // then: inside a message it must still be taken as data.
    function automatic logic [7:0] rand_data();
        return ($urandom_range(4) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(127));
    endfunction

    function automatic logic rand_end();
        return ($urandom_range(11) == 0);
    endfunction

    // A status byte followed by up to two data bytes. Half the statuses are
    // system ones so that every type code turns up; the data count does not
    // always fit the status, which leaves strays and statuses taken as data.
    task automatic send_message();
        logic [7:0] status;
        int         n_data;
        status = ($urandom_range(1) == 0) ? {4'hF, 4'($urandom_range(15))}
                                          : 8'($urandom_range(8'hEF, 8'h80));
        n_data = $urandom_range(3);
        if (n_data > 2) begin
            n_data = 2;
        end
        send_byte(status, rand_end());
        for (int i = 0; i < n_data; i++) begin
            send_byte(rand_data(), rand_end());
        end
    endtask

    // Random traffic until at least the given number of further bytes is accepted:
    // status-led messages with a sprinkling of lone bytes as noise.
    task automatic run_phase(input int snd_pct, input int rcv_pct, input int n_bytes);
        int stop_at;
        stop_at       = bytes_sent + n_bytes;
        snd_idle_pct  = snd_pct;
        rcv_stall_pct <= rcv_pct;
        while (bytes_sent < stop_at) begin
            if ($urandom_range(99) < 15) begin
                send_byte(8'($urandom_range(255)), rand_end());
            end else begin
                send_message();
            end
        end
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed bytes, no idling.
        send_byte(8'h00, 1'b0);     // stray bytes at both ends of the range
        send_byte(8'h7F, 1'b0);
        send_byte(8'h80, 1'b0);     // note off, channel 1, extreme data
        send_byte(8'h00, 1'b0);
        send_byte(8'h7F, 1'b0);
        send_byte(8'h9F, 1'b0);     // note on, channel 16, data with top bit set
        send_byte(8'hFF, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'hC5, 1'b0);     // program change, two bytes
        send_byte(8'h12, 1'b0);
        send_byte(8'hF8, 1'b0);     // clock: one-byte message
        send_byte(8'hF4, 1'b0);     // undefined system status
        send_byte(8'hF0, 1'b0);     // sysex start, not collected
        send_byte(8'hF2, 1'b0);     // song position, three bytes
        send_byte(8'h01, 1'b0);
        send_byte(8'h02, 1'b0);
        send_byte(8'hF1, 1'b0);     // time code, two bytes
        send_byte(8'h55, 1'b0);
        send_byte(8'hB3, 1'b1);     // buffer ends right after the status
        send_byte(8'hE0, 1'b0);     // buffer ends after one data byte
        send_byte(8'h40, 1'b1);
        send_byte(8'hD2, 1'b0);     // message completes on the buffer end
        send_byte(8'h33, 1'b1);
        send_byte(8'hFF, 1'b1);     // one-byte message on the buffer end
        send_byte(8'h2A, 1'b1);     // stray byte on the buffer end

        run_phase(0, 0, 120);
        run_phase(75, 0, 120);
        run_phase(0, 75, 120);
        run_phase(19, 19, 120);
        // Long receiver hold-off while the sender streams flat out.
        hold_token <= hold_token + 1;
        run_phase(0, 0, 120);

        s_tvalid      <= 1'b0;
        rcv_stall_pct <= 0;
        @(posedge i_clk);
        while (pending_count != 0) begin
            @(posedge i_clk);
        end
        // Leave room for any surplus record to show up.
        repeat (8) @(posedge i_clk);

        if (fail_count == 0 && pending_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
